// ===== rtl/core/wps_pkg.sv =====
package wps_pkg;

   typedef enum logic [2:0] {
      MODE_IDLE   = 3'd0,
      MODE_PREFIX = 3'd1,
      MODE_LETTER = 3'd2,
      MODE_DIGIT  = 3'd3,
      MODE_APOS   = 3'd4,
      MODE_HOLD   = 3'd5
   } mode_type;

   localparam logic [7:0] CHAR_APOS  = 8'h27;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LO_A  = 8'h61;
   localparam logic [7:0] CHAR_LO_Z  = 8'h7A;
   localparam logic [7:0] CHAR_UP_A  = 8'h41;
   localparam logic [7:0] CHAR_UP_Z  = 8'h5A;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_S     = 8'h73;
   localparam logic [7:0] CHAR_T     = 8'h74;
   localparam logic [7:0] CHAR_M     = 8'h6D;
   localparam logic [7:0] CHAR_D     = 8'h64;
   localparam logic [7:0] CHAR_R     = 8'h72;
   localparam logic [7:0] CHAR_V     = 8'h76;
   localparam logic [7:0] CHAR_L     = 8'h6C;
   localparam logic [7:0] CHAR_E     = 8'h65;
   localparam logic [7:0] ASCII_TOP  = 8'h7F;

   // Words bound for the result side; a pair carries two bytes.
   typedef struct packed {
      logic       two;
      logic [7:0] byte0;
      logic       start0;
      logic [7:0] byte1;
      logic       start1;
      logic       eot;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } push_type;

   typedef struct packed {
      mode_type mode;
      logic     seen;
      logic     start;
   } adv_type;

   function automatic logic is_letter(input logic [7:0] b);
      return (b >= CHAR_LO_A && b <= CHAR_LO_Z) || (b >= CHAR_UP_A && b <= CHAR_UP_Z) ||
             (b > ASCII_TOP);
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      return b >= CHAR_ZERO && b <= CHAR_NINE;
   endfunction

   function automatic logic is_ws(input logic [7:0] b);
      return b == CHAR_SPACE || b == CHAR_TAB || b == CHAR_LF || b == CHAR_CR;
   endfunction

   function automatic adv_type begin_body(input logic [7:0] b, input logic seen);
      adv_type r;
      r.seen  = seen;
      r.start = 1'b0;
      if (b == CHAR_APOS && seen) begin
         r.mode = MODE_APOS;
      end else if (is_letter(b)) begin
         r.mode = MODE_LETTER;
      end else if (is_digit(b)) begin
         r.mode = MODE_DIGIT;
      end else begin
         r.mode = MODE_IDLE;
         r.seen = 1'b1;
      end
      return r;
   endfunction

   // Feed one byte to the word tracker; start flags a new word.
   function automatic adv_type advance(input mode_type mode, input logic seen,
                                       input logic [7:0] b);
      adv_type r;
      logic    fall;
      logic    seen_w;
      r      = '{mode: mode, seen: seen, start: 1'b0};
      fall   = 1'b1;
      seen_w = seen;
      unique case (mode)
         MODE_LETTER: begin
            if (is_letter(b)) begin
               fall = 1'b0;
            end else begin
               seen_w = 1'b1;
            end
         end
         MODE_DIGIT: begin
            if (is_digit(b)) begin
               fall = 1'b0;
            end else begin
               seen_w = 1'b1;
            end
         end
         MODE_APOS: begin
            seen_w = 1'b1;
            if (b == CHAR_S || b == CHAR_T || b == CHAR_M || b == CHAR_D) begin
               fall = 1'b0;
               r    = '{mode: MODE_IDLE, seen: 1'b1, start: 1'b0};
            end
         end
         MODE_PREFIX: begin
            fall = 1'b0;
            r    = begin_body(b, seen);
         end
         default: begin
            fall = 1'b1;
         end
      endcase
      if (fall) begin
         if (is_ws(b)) begin
            r = '{mode: MODE_PREFIX, seen: seen_w, start: 1'b1};
         end else begin
            r       = begin_body(b, seen_w);
            r.start = 1'b1;
         end
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/wps_front.sv =====
module wps_front
   import wps_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_end_of_text,
   input  logic       push_ready,
   output push_type   push
);

   mode_type   mode_ff, mode_in;
   logic       seen_ff, seen_in;
   logic [7:0] held_ff, held_in;
   logic       held_valid_ff, held_valid_in;

   logic       accept;
   logic       emit;
   entry_type  entry;
   adv_type    a1;
   adv_type    a2;
   logic [7:0] want;

   assign req_ready = push_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      mode_in       = mode_ff;
      seen_in       = seen_ff;
      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      emit          = 1'b0;
      entry         = '0;
      entry.eot     = req_end_of_text;
      want          = (held_ff == CHAR_L) ? CHAR_L : CHAR_E;
      a1            = '0;
      a2            = '0;
      if (mode_ff == MODE_HOLD && held_valid_ff) begin
         emit          = 1'b1;
         entry.two     = 1'b1;
         entry.byte0   = held_ff;
         entry.byte1   = req_data_byte;
         held_in       = '0;
         held_valid_in = 1'b0;
         if (req_data_byte == want) begin
            mode_in = MODE_IDLE;
            seen_in = 1'b1;
         end else begin
            a1           = advance(MODE_IDLE, 1'b1, held_ff);
            a2           = advance(a1.mode, a1.seen, req_data_byte);
            entry.start0 = a1.start;
            entry.start1 = a2.start;
            mode_in      = a2.mode;
            seen_in      = a2.seen;
         end
      end else begin
         a1 = advance((mode_ff == MODE_HOLD) ? MODE_IDLE : mode_ff, seen_ff, req_data_byte);
         // Hold r, v or l after a contraction apostrophe until the next byte.
         if (mode_ff == MODE_APOS && !req_end_of_text &&
             (req_data_byte == CHAR_R || req_data_byte == CHAR_V ||
              req_data_byte == CHAR_L)) begin
            held_in       = req_data_byte;
            held_valid_in = 1'b1;
            mode_in       = MODE_HOLD;
         end else begin
            emit         = 1'b1;
            entry.byte0  = req_data_byte;
            entry.start0 = a1.start;
            mode_in      = a1.mode;
            seen_in      = a1.seen;
         end
      end
      if (req_end_of_text) begin
         mode_in       = MODE_IDLE;
         seen_in       = 1'b0;
         held_in       = '0;
         held_valid_in = 1'b0;
      end
      push.valid = accept && emit;
      push.entry = entry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_IDLE;
         seen_ff       <= 1'b0;
         held_ff       <= '0;
         held_valid_ff <= 1'b0;
      end else if (accept) begin
         mode_ff       <= mode_in;
         seen_ff       <= seen_in;
         held_ff       <= held_in;
         held_valid_ff <= held_valid_in;
      end
   end

endmodule

// ===== rtl/core/wps_back.sv =====
module wps_back
   import wps_pkg::*;
#(
   parameter int QueueDepth = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  push_type   push,
   output logic       push_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_word_start,
   output logic       rsp_text_done,
   output logic       rsp_run_end
);

   localparam int PtrWidth = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int CntWidth = $clog2(QueueDepth + 1);
   localparam logic [PtrWidth-1:0] PtrLast = PtrWidth'(QueueDepth - 1);
   localparam logic [CntWidth-1:0] CntFull = CntWidth'(QueueDepth);

   entry_type             queue_mem [QueueDepth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0]   count_ff, count_in;
   logic                  sub_ff, sub_in;
   logic                  valid_ff, valid_in;
   logic [7:0]            byte_ff;
   logic                  start_ff;
   logic                  done_ff;
   logic                  last_ff;

   entry_type             head;
   logic                  have;
   logic                  load;
   logic                  last;
   logic                  do_push;
   logic                  do_pop;

   assign push_ready = count_ff != CntFull;
   assign do_push    = push.valid && push_ready;
   assign head       = queue_mem[rd_ptr_ff];
   assign have       = count_ff != '0;
   assign load       = have && (!valid_ff || rsp_ready);
   assign last       = !head.two || sub_ff;
   assign do_pop     = load && last;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      sub_in    = sub_ff;
      valid_in  = valid_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
      if (load) begin
         sub_in   = !last;
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         sub_ff    <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         sub_ff    <= sub_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         queue_mem[wr_ptr_ff] <= push.entry;
      end
   end

   // Output stage: take the second byte of a pair at the next load after the first.
   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff  <= sub_ff ? head.byte1 : head.byte0;
         start_ff <= sub_ff ? head.start1 : head.start0;
         done_ff  <= last && head.eot;
         last_ff  <= last;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_out_byte   = byte_ff;
   assign rsp_word_start = start_ff;
   assign rsp_text_done  = done_ff;
   assign rsp_run_end    = last_ff;

endmodule

// ===== rtl/core/text_pretokenizer_word_splitter_unit.sv =====
// Byte-level word splitter: text bytes go in one per cycle while the queue
// has room and come out in the same order, each marked where a new word
// starts (letter runs, digit runs, single other bytes and apostrophe
// contractions, with one whitespace byte leading a word). Throughput is one
// byte per cycle on both sides while the queue has room and rsp_ready is
// high; a front stage updates the word state for each byte and hands its
// results to a QueueDepth-entry queue drained by a registered output stage.
// An r, v or l straight after a contraction apostrophe gives no result
// until the next byte arrives, which then gives two (one per cycle while rsp_ready is high).
// After the byte marked end of text all word state returns to reset.
module text_pretokenizer_word_splitter_unit
   import wps_pkg::*;
#(
   parameter int QueueDepth = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_end_of_text,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_word_start,
   output logic       rsp_text_done,
   output logic       rsp_run_end
);

   push_type push;
   logic     push_ready;

   wps_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_byte   (req_data_byte),
      .req_end_of_text (req_end_of_text),
      .push_ready      (push_ready),
      .push            (push)
   );

   wps_back #(
      .QueueDepth (QueueDepth)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .push_ready     (push_ready),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_word_start (rsp_word_start),
      .rsp_text_done  (rsp_text_done),
      .rsp_run_end    (rsp_run_end)
   );

`ifndef SYNTHESIS
   a_pair_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_run_end |=> rsp_valid)
      else $error("second word of a pair missing");

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_text_done |-> rsp_run_end)
      else $error("end of text flagged before last word of its byte");

   a_push_needs_room: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> push_ready && req_valid)
      else $error("front pushed without an accepted byte");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("output valid after reset");
`endif

endmodule

// ===== verif/text_pretokenizer_word_splitter_unit_test.sv =====
module text_pretokenizer_word_splitter_unit_test;
   import wps_pkg::*;

   localparam int StallLimit = 2000;
   localparam int HoldCycles = 400;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       word_start;
      logic       text_done;
      logic       run_end;
   } byte_mark_type;

   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_MOSTLY,
      READY_SPARSE,
      READY_TOGGLE
   } ready_style_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_end_of_text = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_word_start;
   logic       rsp_text_done;
   logic       rsp_run_end;

   // Word tracker state of the predictor
   mode_type   track_mode = MODE_IDLE;
   logic       track_seen = 1'b0;
   logic [7:0] held_char = 8'h00;
   logic       held_live = 1'b0;

   byte_mark_type marks_due[$];
   logic [7:0]    text_buf[$];
   int            mismatches = 0;
   int            burst_left = 0;
   bit            allow_gaps = 1'b1;
   bit            rsp_long_hold = 1'b0;

   text_pretokenizer_word_splitter_unit i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_byte   (req_data_byte),
      .req_end_of_text (req_end_of_text),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_word_start  (rsp_word_start),
      .rsp_text_done   (rsp_text_done),
      .rsp_run_end     (rsp_run_end)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void queue_mark(input byte_mark_type m);
      marks_due.insert(marks_due.size(), m);
   endfunction

   function automatic void add_char(input logic [7:0] b);
      text_buf.insert(text_buf.size(), b);
   endfunction

   function automatic logic alpha_char(input logic [7:0] b);
      logic [7:0] folded;
      folded = b | 8'h20;
      return b > ASCII_TOP || (folded >= CHAR_LO_A && folded <= CHAR_LO_Z);
   endfunction

   function automatic logic num_char(input logic [7:0] b);
      return b >= CHAR_ZERO && b <= CHAR_NINE;
   endfunction

   function automatic logic space_char(input logic [7:0] b);
      return b == CHAR_SPACE || b == CHAR_TAB || b == CHAR_LF || b == CHAR_CR;
   endfunction

   function automatic void open_body(input logic [7:0] b);
      if (b == CHAR_APOS && track_seen) begin
         track_mode = MODE_APOS;
      end else if (alpha_char(b)) begin
         track_mode = MODE_LETTER;
      end else if (num_char(b)) begin
         track_mode = MODE_DIGIT;
      end else begin
         track_mode = MODE_IDLE;
         track_seen = 1'b1;
      end
   endfunction

   // Track one byte through the word state; return its word start mark.
   function automatic logic mark_word_start(input logic [7:0] b);
      logic breaks;
      breaks = 1'b1;
      case (track_mode)
         MODE_LETTER: begin
            if (alpha_char(b)) breaks = 1'b0;
            else track_seen = 1'b1;
         end
         MODE_DIGIT: begin
            if (num_char(b)) breaks = 1'b0;
            else track_seen = 1'b1;
         end
         MODE_APOS: begin
            track_seen = 1'b1;
            track_mode = MODE_IDLE;
            if (b == CHAR_S || b == CHAR_T || b == CHAR_M || b == CHAR_D) breaks = 1'b0;
         end
         MODE_PREFIX: begin
            open_body(b);
            breaks = 1'b0;
         end
         default: begin
         end
      endcase
      if (breaks) begin
         track_mode = MODE_IDLE;
         if (space_char(b)) track_mode = MODE_PREFIX;
         else open_body(b);
      end
      return breaks;
   endfunction

   function automatic void predict_marks(input logic [7:0] b, input logic eot);
      logic [7:0] h;
      logic [7:0] want;
      logic       s1;
      logic       s2;
      if (track_mode == MODE_HOLD && held_live) begin
         h    = held_char;
         want = (h == CHAR_L) ? CHAR_L : CHAR_E;
         held_live = 1'b0;
         held_char = 8'h00;
         track_mode = MODE_IDLE;
         track_seen = 1'b1;
         if (b == want) begin
            s1 = 1'b0;
            s2 = 1'b0;
         end else begin
            s1 = mark_word_start(h);
            s2 = mark_word_start(b);
         end
         queue_mark('{out_byte: h, word_start: s1, text_done: 1'b0, run_end: 1'b0});
         queue_mark('{out_byte: b, word_start: s2, text_done: eot, run_end: 1'b1});
      end else begin
         if (track_mode == MODE_HOLD) track_mode = MODE_IDLE;
         if (track_mode == MODE_APOS && !eot && (b == CHAR_R || b == CHAR_V || b == CHAR_L))
         begin
            // hold r, v or l until the next byte settles the pair
            held_char  = b;
            held_live  = 1'b1;
            track_mode = MODE_HOLD;
         end else begin
            s1 = mark_word_start(b);
            queue_mark('{out_byte: b, word_start: s1, text_done: eot, run_end: 1'b1});
         end
      end
      if (eot) begin
         track_mode = MODE_IDLE;
         track_seen = 1'b0;
         held_char  = 8'h00;
         held_live  = 1'b0;
      end
   endfunction

   task automatic send_text_byte(input logic [7:0] b, input logic eot);
      int gap;
      if (allow_gaps && burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      if (burst_left > 0) burst_left--;
      @(negedge clock);
      req_valid       <= 1'b1;
      req_data_byte   <= b;
      req_end_of_text <= eot;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_marks(b, eot);
   endtask

   task automatic send_string(input string text, input logic eot_last);
      int i;
      for (i = 0; i < text.len(); i++) begin
         send_text_byte(text[i], eot_last && i == text.len() - 1);
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (marks_due.size() != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] rand_letter();
      case ($urandom_range(0, 3))
         0:       return 8'(CHAR_UP_A + $urandom_range(0, 25));
         1:       return 8'($urandom_range(8'h80, 8'hFF));
         default: return 8'(CHAR_LO_A + $urandom_range(0, 25));
      endcase
   endfunction

   function automatic void add_token();
      int n;
      int i;
      logic [7:0] pick;
      case ($urandom_range(0, 9))
         0, 1: begin
            n = $urandom_range(1, 6);
            for (i = 0; i < n; i++) add_char(rand_letter());
         end
         2: begin
            n = $urandom_range(1, 4);
            for (i = 0; i < n; i++) add_char(8'(CHAR_ZERO + $urandom_range(0, 9)));
         end
         3: begin
            n = $urandom_range(1, 2);
            for (i = 0; i < n; i++) begin
               case ($urandom_range(0, 3))
                  0:       add_char(CHAR_TAB);
                  1:       add_char(CHAR_LF);
                  2:       add_char(CHAR_CR);
                  default: add_char(CHAR_SPACE);
               endcase
            end
         end
         4, 5: begin
            add_char(CHAR_APOS);
            case ($urandom_range(0, 3))
               0: pick = CHAR_R;
               1: pick = CHAR_V;
               2: pick = CHAR_L;
               default: pick = CHAR_S;
            endcase
            case ($urandom_range(0, 9))
               0: add_char(CHAR_S);
               1: add_char(CHAR_T);
               2: add_char(CHAR_M);
               3: add_char(CHAR_D);
               4: begin
                  add_char(CHAR_R);
                  add_char(CHAR_E);
               end
               5: begin
                  add_char(CHAR_V);
                  add_char(CHAR_E);
               end
               6: begin
                  add_char(CHAR_L);
                  add_char(CHAR_L);
               end
               7: begin
                  // r, v, l or s after the apostrophe, with a letter behind it
                  add_char(pick);
                  add_char(rand_letter());
               end
               8: begin
                  add_char(pick);
                  add_char(8'($urandom_range(0, 255)));
               end
               default: add_char(pick);
            endcase
         end
         6, 7: add_char(8'($urandom_range(0, 255)));
         8: begin
            add_char(CHAR_SPACE);
            n = $urandom_range(1, 6);
            for (i = 0; i < n; i++) add_char(rand_letter());
         end
         default: begin
            add_char(CHAR_APOS);
            add_char(8'($urandom_range(0, 255)));
         end
      endcase
   endfunction

   task automatic send_random_text(input int count);
      int sent;
      int seg_len;
      int i;
      sent = 0;
      while (sent < count) begin
         seg_len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 48);
         text_buf.delete();
         if ($urandom_range(0, 9) == 0) begin
            for (i = 0; i < seg_len; i++) add_char(8'($urandom_range(0, 255)));
         end else begin
            while (text_buf.size() < seg_len) add_token();
         end
         for (i = 0; i < seg_len; i++) send_text_byte(text_buf[i], i == seg_len - 1);
         sent += seg_len;
         if ($urandom_range(0, 15) == 0) wait_drained();
      end
   endtask

   task automatic test_byte_extremes();
      send_text_byte(8'h00, 1'b0);
      send_text_byte(ASCII_TOP, 1'b0);
      send_text_byte(ASCII_TOP + 8'd1, 1'b0);
      send_text_byte(8'hFF, 1'b1);
   endtask

   // Pair completes, pair fails, short contraction and l at end of text
   task automatic test_contractions();
      send_string("I'll 9've x'rz'd'l", 1'b1);
   endtask

   // Leading apostrophe, whitespace after prefix, lone prefix
   task automatic test_whitespace();
      send_text_byte(CHAR_APOS, 1'b0);
      send_text_byte(CHAR_SPACE, 1'b0);
      send_text_byte(CHAR_TAB, 1'b0);
      send_text_byte(CHAR_CR, 1'b1);
   endtask

   task automatic test_output_backpressure();
      allow_gaps    = 1'b0;
      rsp_long_hold = 1'b1;
      send_random_text(40);
      wait_drained();
      while (rsp_long_hold) @(posedge clock);
      allow_gaps = 1'b1;
   endtask

   task automatic test_drain_pause();
      send_random_text(20);
      wait_drained();
      send_random_text(20);
   endtask

   task automatic test_random_text();
      send_random_text(950);
   endtask

   initial begin
      ready_style_type style;
      int              seg_left;
      style    = READY_ALWAYS;
      seg_left = 0;
      forever begin
         @(negedge clock);
         if (rsp_long_hold) begin
            rsp_ready <= 1'b0;
            repeat (HoldCycles) @(negedge clock);
            rsp_long_hold = 1'b0;
         end else begin
            if (seg_left == 0) begin
               seg_left = $urandom_range(1, 64);
               style    = ready_style_type'($urandom_range(0, 3));
            end
            seg_left--;
            case (style)
               READY_ALWAYS: rsp_ready <= 1'b1;
               READY_MOSTLY: rsp_ready <= ($urandom_range(0, 3) != 0);
               READY_SPARSE: rsp_ready <= ($urandom_range(0, 2) == 0);
               default:      rsp_ready <= ~rsp_ready;
            endcase
         end
      end
   end

   always @(posedge clock) begin : check_words
      byte_mark_type due;
      if (!reset && rsp_valid && rsp_ready) begin
         if (marks_due.size() == 0) begin
            $error("unexpected word: out_byte %h", rsp_out_byte);
            mismatches++;
         end else begin
            due = marks_due.pop_front();
            if (rsp_out_byte !== due.out_byte) begin
               $error("out_byte: expected %h, actual %h", due.out_byte, rsp_out_byte);
               mismatches++;
            end
            if (rsp_word_start !== due.word_start) begin
               $error("word_start: expected %b, actual %b", due.word_start, rsp_word_start);
               mismatches++;
            end
            if (rsp_text_done !== due.text_done) begin
               $error("text_done: expected %b, actual %b", due.text_done, rsp_text_done);
               mismatches++;
            end
            if (rsp_run_end !== due.run_end) begin
               $error("run_end: expected %b, actual %b", due.run_end, rsp_run_end);
               mismatches++;
            end
         end
      end
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < StallLimit) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("status: fail");
      $finish;
   end

   initial begin
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      test_byte_extremes();
      test_contractions();
      test_whitespace();
      test_output_backpressure();
      test_drain_pause();
      test_random_text();
      wait_drained();
      repeat (8) @(posedge clock);
      if (mismatches == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule
